### hdl/assert_macros.svh
// assert_macros.svh - shorthand for the concurrent checks of the cosine distance unit.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CDU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CDU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cdu_pkg.sv
// cdu_pkg.sv - widths, codes and shared types of the cosine distance unit.
// No dependencies; imported by every module of the block.
package cdu_pkg;

  // Field and register widths
  localparam int DIMS_W   = 11;
  localparam int VAL_W    = 16;
  localparam int IDX_W    = 16;
  localparam int DIST_W   = 18;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Accumulators: dims is 11 bits, so at most 2047 squares of up to 2^30
  localparam int SQ_W     = 31;
  localparam int PROD_W   = 32;
  localparam int NORM_W   = 41;
  localparam int DOT_W    = 42;
  localparam int MAG_W    = 41;

  // Back end datapath
  localparam int PRODUCT_W = 2 * NORM_W;
  localparam int ROOT_W    = NORM_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int FRAC_W    = 16;
  localparam int DIVD_W    = MAG_W + FRAC_W;
  localparam int CNT_W     = 6;
  localparam int MUL_STEPS  = NORM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = DIVD_W;

  // Stream packing
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - DIST_W;

  // Defaults for the top level parameters
  localparam int MAX_DIM_DEF     = 1024;
  localparam int MAX_VECTORS_DEF = 65536;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 11'd128;
  localparam logic [DIST_W-1:0] DIST_ONE   = 18'd65536;
  localparam logic [DIST_W-1:0] DIST_MAX   = 18'd131072;

  // Command codes (tuser of the input stream)
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_CAND  = 1'b1;

  // Register index, taken from paddr word bit
  localparam logic REG_DIMS = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } be_state_e;

  // Finished candidate handed from the accumulator to the back end
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       qn;
    logic [NORM_W-1:0]       cn;
    logic [IDX_W-1:0]        idx;
  } job_t;

  // One result item
  typedef struct packed {
    logic              degen;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

### hdl/cosine_distance_unit.sv
// cosine_distance_unit.sv - top level: streams, APB register, front and back end.
// Depends on cdu_pkg, cdu_front, cdu_back and assert_macros.svh.
//
// Elements arrive one transfer per cycle on the input stream (tuser 0 loads the
// next query element, 1 supplies the next candidate element). Query elements go
// to an on-chip store of MAX_DIM entries; candidate elements read it back and
// feed a three-stage accumulate pipeline. After a candidate's last element the
// sums pass to a serial back end that forms the norm product, then the square
// root, then the division, and last loads the output register that drives the
// output stream. The input takes an element every cycle, except that whenever
// the next candidate position is a vector's last, any element waits until the
// previous candidate has left the back end; the back end itself holds its
// finished result while an older one still sits unread on the output. The query
// store has no reset and needs no clearing pass; only load a query before
// sending candidates.
`include "assert_macros.svh"

module cosine_distance_unit import cdu_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int MAX_VECTORS = MAX_VECTORS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [VAL_W-1:0]       s_axis_tdata,   // [15:0] value
  input  logic                   s_axis_tuser,   // [0] cmd
  // Output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [17:0] distance, [33:18] vector_index
  output logic                   m_axis_tuser,   // [0] degenerate
  // APB register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  // Configuration register
  logic [DIMS_W-1:0] dims_q;
  logic              apb_wr;

  assign pready = 1'b1;
  assign apb_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_RESET;
    end else if (apb_wr && (paddr[2] == REG_DIMS)) begin
      dims_q <= pwdata[DIMS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_DIMS) ? APB_DW'(dims_q) : '0;

  // Front end and back end
  logic be_idle, job_valid, res_valid;
  job_t job;
  res_t res;

  cdu_front #(
    .MAX_DIM     (MAX_DIM),
    .MAX_VECTORS (MAX_VECTORS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_value_i  ($signed(s_axis_tdata)),
    .be_idle_i   (be_idle),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  cdu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .idle_o      (be_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res.idx, res.distance};
  assign m_axis_tuser  = res.degen;

  // Checks
  logic [DIST_W-1:0] out_dist;

  assign out_dist = m_axis_tdata[DIST_W-1:0];

  `CDU_ASSERT_IMP(a_job_to_idle, job_valid, be_idle, "candidate handed to a busy back end")
  `CDU_ASSERT_NXT(a_job_starts, job_valid, !be_idle, "back end did not take the candidate")
  `CDU_ASSERT_IMP(a_degen_one, m_axis_tvalid && m_axis_tuser, out_dist == DIST_ONE, "degen not one")
  `CDU_ASSERT_IMP(a_dist_range, m_axis_tvalid, out_dist <= DIST_MAX, "distance out of range")

endmodule

### hdl/cdu_qmem.sv
// cdu_qmem.sv - query element store, one write and one registered read port.
// Takes the element width and default depth from cdu_pkg; no submodules.
module cdu_qmem import cdu_pkg::*; #(
  parameter int DEPTH = MAX_DIM_DEF,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [VAL_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cdu_front.sv
// cdu_front.sv - element pipeline: position tracking, query store access, products, sums.
// Depends on cdu_pkg and cdu_qmem; hands finished candidates to cdu_back.
module cdu_front import cdu_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int MAX_VECTORS = MAX_VECTORS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [DIMS_W-1:0]       dims_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    in_cmd_i,
  input  logic signed [VAL_W-1:0] in_value_i,
  input  logic                    be_idle_i,
  output logic                    job_valid_o,
  output job_t                    job_o
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(MAX_VECTORS);

  // Effective vector length: 0 acts as 1, clipped to the store depth
  logic [NW-1:0] n;
  logic [AW-1:0] n_last;

  always_comb begin
    if (dims_i == '0) begin
      n = NW'(1);
    end else if (32'(dims_i) > 32'(MAX_DIM)) begin
      n = NW'(MAX_DIM);
    end else begin
      n = NW'(dims_i);
    end
  end

  assign n_last = AW'(n - NW'(1));

  // Stage 0: positions and counters
  logic [AW-1:0] qpos_q, cpos_q;
  logic [CW-1:0] ccnt_q, ccnt_inc;
  logic [AW-1:0] q_addr, c_addr;
  logic          q_wrap, c_last, is_q, take, last_pend;

  logic                    s1_valid_q, s1_cmd_q, s1_clr_q, s1_last_q;
  logic signed [VAL_W-1:0] s1_val_q;
  logic [IDX_W-1:0]        s1_idx_q;

  logic                     s2_valid_q, s2_cmd_q, s2_clr_q, s2_last_q;
  logic [IDX_W-1:0]         s2_idx_q;
  logic [SQ_W-1:0]          sq_q;
  logic signed [PROD_W-1:0] prod_q;

  assign q_addr = (NW'(qpos_q) >= n) ? n_last : qpos_q;
  assign q_wrap = (NW'(q_addr) + NW'(1)) >= n;
  assign c_addr = (NW'(cpos_q) >= n) ? n_last : cpos_q;
  assign c_last = (NW'(cpos_q) + NW'(1)) >= n;
  assign ccnt_inc = ((32'(ccnt_q) + 32'd1) >= 32'(MAX_VECTORS)) ? '0 : ccnt_q + CW'(1);
  assign is_q = (in_cmd_i == CMD_QUERY);

  // Hold off the next vector end while a finished candidate is still in flight
  assign last_pend  = (s1_valid_q & s1_last_q) | (s2_valid_q & s2_last_q) | !be_idle_i;
  assign in_ready_o = !(c_last & last_pend);
  assign take       = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qpos_q <= '0;
      cpos_q <= '0;
      ccnt_q <= '0;
    end else if (take) begin
      if (is_q) begin
        qpos_q <= q_wrap ? '0 : q_addr + AW'(1);
        if (qpos_q == '0) begin
          cpos_q <= '0;
          ccnt_q <= '0;
        end
      end else begin
        cpos_q <= c_last ? '0 : cpos_q + AW'(1);
        if (c_last) begin
          ccnt_q <= ccnt_inc;
        end
      end
    end
  end

  // Query store: query elements write, candidate elements read
  logic [VAL_W-1:0]        mem_rdata;
  logic signed [VAL_W-1:0] q_rd;

  cdu_qmem #(
    .DEPTH (MAX_DIM),
    .AW    (AW)
  ) u_qmem (
    .clk_i   (clk_i),
    .we_i    (take & is_q),
    .waddr_i (q_addr),
    .wdata_i (in_value_i),
    .re_i    (take & !is_q),
    .raddr_i (c_addr),
    .rdata_o (mem_rdata)
  );

  assign q_rd = mem_rdata;

  // Stage 1: wait for the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_cmd_q  <= in_cmd_i;
      s1_val_q  <= in_value_i;
      s1_clr_q  <= is_q & (qpos_q == '0);
      s1_last_q <= !is_q & c_last;
      s1_idx_q  <= IDX_W'(ccnt_q);
    end
  end

  // Stage 1 -> 2: element products
  logic signed [PROD_W-1:0] prod_w, sq_w;

  assign prod_w = q_rd * s1_val_q;
  assign sq_w   = s1_val_q * s1_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_clr_q  <= s1_clr_q;
      s2_last_q <= s1_last_q;
      s2_idx_q  <= s1_idx_q;
      sq_q      <= sq_w[SQ_W-1:0];
      prod_q    <= prod_w;
    end
  end

  // Stage 2: sums
  logic [NORM_W-1:0]       qn_q, cn_q, cn_n;
  logic signed [DOT_W-1:0] dot_q, dot_n;
  logic                    s2_end;

  assign dot_n  = dot_q + DOT_W'(prod_q);
  assign cn_n   = cn_q + NORM_W'(sq_q);
  assign s2_end = s2_valid_q & (s2_cmd_q == CMD_CAND) & s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qn_q  <= '0;
      cn_q  <= '0;
      dot_q <= '0;
    end else if (s2_valid_q) begin
      if (s2_cmd_q == CMD_QUERY) begin
        if (s2_clr_q) begin
          qn_q  <= NORM_W'(sq_q);
          cn_q  <= '0;
          dot_q <= '0;
        end else begin
          qn_q <= qn_q + NORM_W'(sq_q);
        end
      end else if (s2_last_q) begin
        cn_q  <= '0;
        dot_q <= '0;
      end else begin
        cn_q  <= cn_n;
        dot_q <= dot_n;
      end
    end
  end

  assign job_valid_o = s2_end;
  assign job_o       = '{dot: dot_n, qn: qn_q, cn: cn_n, idx: s2_idx_q};

endmodule

### hdl/cdu_back.sv
// cdu_back.sv - per-candidate back end: norm product, integer square root, division.
// Depends on cdu_pkg; one shared subtractor serves the root and the quotient.
module cdu_back import cdu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic idle_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic res_ready_i
);

  be_state_e st_q, st_d;

  logic [CNT_W-1:0]     cnt_q;
  logic [PRODUCT_W-1:0] acc_q, ma_q;
  logic [NORM_W-1:0]    mb_q;
  logic [ROOT_W-1:0]    root_q;
  logic [REM_W-1:0]     rem_q;
  logic [DIST_W-1:0]    quo_q;
  logic                 ovf_q, neg_q, degen_q;
  logic [MAG_W-1:0]     mag_q;
  logic [IDX_W-1:0]     idx_q;

  logic res_valid_q;
  res_t res_q;

  logic job_degen, res_free, load_res, step_last;

  assign job_degen = (job_i.qn == '0) || (job_i.cn == '0);
  assign res_free  = !res_valid_q || res_ready_i;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          st_d = job_degen ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (step_last) st_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (step_last) st_d = ST_DIV;
      end
      ST_DIV: begin
        if (step_last) st_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_free) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    idle_o    = 1'b0;
    load_res  = 1'b0;
    step_last = (cnt_q == '0);
    case (st_q)
      ST_IDLE: idle_o   = 1'b1;
      ST_DONE: load_res = res_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Shared compare/subtract for root and quotient digits
  logic [REM_W-1:0]     sq_rem_sh, dv_rem_sh, trial, op_a, op_b, rem_sub;
  logic [REM_W:0]       diff;
  logic                 ge;
  logic [ROOT_W-1:0]    root_next;
  logic [DIST_W-1:0]    quo_next;
  logic [DOT_W-1:0]     mag_w;

  assign sq_rem_sh = {rem_q[REM_W-3:0], acc_q[PRODUCT_W-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign dv_rem_sh = {rem_q[REM_W-2:0], acc_q[DIVD_W-1]};
  assign op_a      = (st_q == ST_SQRT) ? sq_rem_sh : dv_rem_sh;
  assign op_b      = (st_q == ST_SQRT) ? trial : REM_W'(root_q);
  assign diff      = {1'b0, op_a} - {1'b0, op_b};
  assign ge        = !diff[REM_W];
  assign rem_sub   = diff[REM_W-1:0];
  assign root_next = {root_q[ROOT_W-2:0], ge};
  assign quo_next  = {quo_q[DIST_W-2:0], ge};
  assign mag_w     = job_i.dot[DOT_W-1] ? DOT_W'(-job_i.dot) : DOT_W'(job_i.dot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (st_q)
        ST_IDLE: cnt_q <= CNT_W'(MUL_STEPS - 1);
        ST_MUL:  cnt_q <= step_last ? CNT_W'(SQRT_STEPS - 1) : cnt_q - CNT_W'(1);
        ST_SQRT: cnt_q <= step_last ? CNT_W'(DIV_STEPS - 1) : cnt_q - CNT_W'(1);
        ST_DIV:  cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          acc_q   <= '0;
          ma_q    <= PRODUCT_W'(job_i.qn);
          mb_q    <= job_i.cn;
          mag_q   <= mag_w[MAG_W-1:0];
          neg_q   <= job_i.dot[DOT_W-1];
          idx_q   <= job_i.idx;
          degen_q <= job_degen;
        end
      end
      // Shift-add product of the two norms, one multiplier bit a cycle
      ST_MUL: begin
        if (mb_q[0]) acc_q <= acc_q + ma_q;
        ma_q <= ma_q << 1;
        mb_q <= mb_q >> 1;
        if (step_last) begin
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      // Square root, two radicand bits a cycle; last step loads the dividend
      ST_SQRT: begin
        if (step_last) begin
          root_q <= root_next | ROOT_W'(root_next == '0);
          acc_q  <= PRODUCT_W'({mag_q, FRAC_W'(0)});
          rem_q  <= '0;
          quo_q  <= '0;
          ovf_q  <= 1'b0;
        end else begin
          rem_q  <= ge ? rem_sub : sq_rem_sh;
          acc_q  <= acc_q << 2;
          root_q <= root_next;
        end
      end
      // Restoring division, one quotient bit a cycle, saturating
      ST_DIV: begin
        rem_q <= ge ? rem_sub : dv_rem_sh;
        quo_q <= quo_next;
        ovf_q <= ovf_q | quo_q[DIST_W-1];
        acc_q <= acc_q << 1;
      end
      default: ;
    endcase
  end

  // Result formatting
  logic [DIST_W-1:0] quo_sat, dist_val;

  assign quo_sat = (ovf_q || (quo_q > DIST_ONE)) ? DIST_ONE : quo_q;
  always_comb begin
    if (degen_q) begin
      dist_val = DIST_ONE;
    end else if (neg_q) begin
      dist_val = DIST_ONE + quo_sat;
    end else begin
      dist_val = DIST_ONE - quo_sat;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_res) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q <= '{degen: degen_q, idx: idx_q, distance: dist_val};
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### tb/tb_cosine_distance_unit.sv
// tb_cosine_distance_unit.sv - self-checking bench for the cosine distance unit: directed
// cases, a backpressure run and random element streams, scored against a local predictor.
// Depends on cdu_pkg and cosine_distance_unit.
module tb_cosine_distance_unit;
  import cdu_pkg::*;

  localparam int MAX_DIM       = MAX_DIM_DEF;
  localparam int RANDOM_ITEMS  = 800;
  localparam int SETTLE_CYCLES = 200;
  localparam logic [APB_AW-1:0] DIMS_ADDR = {REG_DIMS, 2'b00};

  // Content shapes for generated candidates
  typedef enum int {
    SHAPE_ZERO,
    SHAPE_SAME,
    SHAPE_OPPOSITE,
    SHAPE_SCALED,
    SHAPE_RANDOM
  } shape_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [VAL_W-1:0]       s_axis_tdata;   // [15:0] value
  logic                   s_axis_tuser;   // [0] cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [17:0] distance, [33:18] vector_index
  logic                   m_axis_tuser;   // [0] degenerate
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  cosine_distance_unit DUT (.*);

  // Predictor state
  logic signed [VAL_W-1:0] query_mem [MAX_DIM];
  bit                      query_seen [MAX_DIM];
  longint unsigned         qnorm_ref;
  longint unsigned         cand_norm;
  longint                  dot_acc;
  int unsigned             query_at;
  int unsigned             cand_at;
  logic [IDX_W-1:0]        cand_idx;
  logic [DIMS_W-1:0]       dims_reg;
  res_t                    dist_expected [$];

  int error_count;
  int items_sent;
  int feed_gap_max;
  int sink_gap_max;
  int sink_hold;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Effective vector length
  function automatic int unsigned vec_len();
    if (dims_reg == 0) return 1;
    if (dims_reg > MAX_DIM) return MAX_DIM;
    return dims_reg;
  endfunction

  // Query slot the next candidate element multiplies against
  function automatic int unsigned cand_slot();
    return (cand_at < vec_len()) ? cand_at : vec_len() - 1;
  endfunction

  function automatic longint unsigned isqrt_floor(logic [95:0] p);
    logic [95:0] r;
    logic [95:0] t;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      t = r | (96'd1 << b);
      if (t * t <= p) r = t;
    end
    return r[63:0];
  endfunction

  // Distance of the candidate that just completed
  function automatic res_t finish_candidate();
    res_t            r;
    logic [95:0]     prod;
    longint unsigned root;
    longint unsigned mag;
    longint unsigned quo;
    r.idx = cand_idx;
    if (qnorm_ref == 0 || cand_norm == 0) begin
      r.distance = DIST_ONE;
      r.degen    = 1'b1;
    end else begin
      prod = 96'(qnorm_ref) * 96'(cand_norm);
      root = isqrt_floor(prod);
      if (root == 0) root = 1;
      mag = (dot_acc < 0) ? -dot_acc : dot_acc;
      quo = (mag << 16) / root;
      if (quo > DIST_ONE) quo = DIST_ONE;
      r.distance = (dot_acc < 0) ? DIST_ONE + DIST_W'(quo) : DIST_ONE - DIST_W'(quo);
      r.degen    = 1'b0;
    end
    return r;
  endfunction

  // Advance the predictor by one accepted element
  function automatic void fold_element(logic cmd, logic signed [VAL_W-1:0] v);
    int unsigned n;
    longint      sq;
    n  = vec_len();
    sq = longint'(v) * longint'(v);
    if (cmd == CMD_QUERY) begin
      // first query element restarts everything, partial candidate included
      if (query_at == 0) begin
        qnorm_ref = 0;
        dot_acc   = 0;
        cand_norm = 0;
        cand_at   = 0;
        cand_idx  = '0;
      end
      if (query_at >= n) query_at = n - 1;
      query_mem[query_at]  = v;
      query_seen[query_at] = 1'b1;
      qnorm_ref += sq;
      query_at++;
      if (query_at >= n) query_at = 0;
    end else begin
      dot_acc   += longint'(query_mem[cand_slot()]) * longint'(v);
      cand_norm += sq;
      if (cand_at + 1 < n) begin
        cand_at++;
      end else begin
        dist_expected.push_back(finish_candidate());
        dot_acc   = 0;
        cand_norm = 0;
        cand_at   = 0;
        cand_idx++;
      end
    end
  endfunction

  // One element transfer on the input stream, with a random gap ahead of it
  task automatic send_elem(logic cmd, logic [VAL_W-1:0] v);
    int gap;
    gap = $urandom_range(feed_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fold_element(cmd, v);
    items_sent++;
  endtask

  task automatic send_pair(logic cmd, logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    send_elem(cmd, a);
    send_elem(cmd, b);
  endtask

  // Let every pending result drain, then cover work that yields no result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (dist_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic read_dims();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= DIMS_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[DIMS_W-1:0] !== dims_reg) begin
      $error("dims expected %0d got %0d", dims_reg, prdata[DIMS_W-1:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register write only once the block has gone quiet, then read back
  task automatic set_dims(int unsigned d);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIMS_ADDR;
    pwdata  <= APB_DW'(d);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    dims_reg = DIMS_W'(d);
    read_dims();
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return VAL_W'($urandom_range(8)) - VAL_W'(4);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Candidate element shaped after the query slot it meets
  task automatic send_cand_elem(shape_e sh);
    logic signed [VAL_W-1:0] q;
    logic [VAL_W-1:0]        v;
    // never-loaded slot: feed a query element instead
    if (!query_seen[cand_slot()]) begin
      send_elem(CMD_QUERY, pick_value());
      return;
    end
    q = query_mem[cand_slot()];
    case (sh)
      SHAPE_ZERO:     v = '0;
      SHAPE_SAME:     v = q;
      SHAPE_OPPOSITE: v = -q;
      SHAPE_SCALED:   v = q >>> $urandom_range(1, 8);
      default:        v = pick_value();
    endcase
    send_elem(CMD_CAND, v);
  endtask

  // Result side: per-result stall once valid shows, plus an optional long hold
  initial begin : result_sink
    int   stall;
    bit   armed;
    bit   xfer;
    res_t want;
    stall = 0;
    armed = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      xfer = rst_ni && m_axis_tready && m_axis_tvalid;
      if (xfer) begin
        armed = 1'b0;
        if (dist_expected.size() == 0) begin
          $error("unexpected result: distance %0d vector_index %0d",
                 m_axis_tdata[DIST_W-1:0], m_axis_tdata[DIST_W+IDX_W-1:DIST_W]);
          error_count++;
        end else begin
          want = dist_expected.pop_front();
          if (m_axis_tdata[DIST_W-1:0] !== want.distance) begin
            $error("distance expected %0d got %0d", want.distance,
                   m_axis_tdata[DIST_W-1:0]);
            error_count++;
          end
          if (m_axis_tdata[DIST_W+IDX_W-1:DIST_W] !== want.idx) begin
            $error("vector_index expected %0d got %0d", want.idx,
                   m_axis_tdata[DIST_W+IDX_W-1:DIST_W]);
            error_count++;
          end
          if (m_axis_tuser !== want.degen) begin
            $error("degenerate expected %0d got %0d", want.degen, m_axis_tuser);
            error_count++;
          end
        end
      end else if (!armed && rst_ni && m_axis_tvalid === 1'b1) begin
        stall = $urandom_range(sink_gap_max);
        armed = 1'b1;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap_max == 0 || (armed && stall == 0)) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        if (armed) stall--;
      end
    end
  end

  task automatic test_reset_value();
    read_dims();
  endtask

  // Zero query norm, then zero candidate norm
  task automatic test_degenerate();
    set_dims(2);
    send_pair(CMD_QUERY, 16'd0, 16'd0);
    send_pair(CMD_CAND, 16'h1234, 16'h8001);
    send_pair(CMD_QUERY, 16'd100, -16'sd3);
    send_pair(CMD_CAND, 16'd0, 16'd0);
  endtask

  // Full-scale elements: identical, opposite and mixed vectors
  task automatic test_extremes();
    set_dims(2);
    send_pair(CMD_QUERY, 16'h8000, 16'h7FFF);
    send_pair(CMD_CAND, 16'h8000, 16'h7FFF);
    send_pair(CMD_CAND, 16'h7FFF, 16'h8000);
    send_pair(CMD_CAND, 16'h8000, 16'h8000);
  endtask

  // Query reload begun but unfinished: stale slots against a tiny norm overshoot
  task automatic test_overshoot();
    set_dims(2);
    send_pair(CMD_QUERY, 16'h7FFF, 16'h7FFF);
    send_elem(CMD_QUERY, 16'd1);
    send_pair(CMD_CAND, 16'h7FFF, 16'h7FFF);
    send_pair(CMD_CAND, 16'h8001, 16'h8001);
    send_elem(CMD_QUERY, -16'sd5);
    send_pair(CMD_CAND, 16'h8000, 16'd0);
  endtask

  // A new query after wrap drops the partial candidate and resets the index
  task automatic test_query_restart();
    set_dims(3);
    repeat (3) send_elem(CMD_QUERY, pick_value());
    send_pair(CMD_CAND, pick_value(), pick_value());
    repeat (3) send_elem(CMD_QUERY, pick_value());
    repeat (3) send_elem(CMD_CAND, pick_value());
  endtask

  // Shrinking the length mid-vector, and a length of zero acting as one
  task automatic test_length_change();
    set_dims(4);
    repeat (4) send_elem(CMD_QUERY, pick_value());
    repeat (3) send_elem(CMD_QUERY, pick_value());
    repeat (3) send_elem(CMD_CAND, pick_value());
    set_dims(2);
    send_elem(CMD_CAND, pick_value());
    send_elem(CMD_QUERY, pick_value());
    set_dims(0);
    send_elem(CMD_QUERY, pick_value());
    send_pair(CMD_CAND, pick_value(), pick_value());
  endtask

  // Over-range length clipped to the store depth: a full-depth full-scale query
  // must wrap, so after a short length the next query element restarts
  task automatic test_widest();
    feed_gap_max = 0;
    set_dims(2047);
    repeat (MAX_DIM) send_elem(CMD_QUERY, 16'h8000);
    set_dims(1);
    send_elem(CMD_CAND, 16'h8000);
    send_elem(CMD_QUERY, 16'h7FFF);
    send_elem(CMD_CAND, 16'h8001);
    feed_gap_max = 9;
  endtask

  // Receiver holds off while single-element candidates keep coming
  task automatic test_backpressure();
    set_dims(1);
    send_elem(CMD_QUERY, 16'd20000);
    feed_gap_max = 0;
    sink_hold    = 3000;
    repeat (40) send_elem(CMD_CAND, pick_value());
    feed_gap_max = 9;
  endtask

  // Random phases: mostly whole vectors with shaped content, some fragments and noise
  task automatic test_random();
    int     base;
    int     action;
    int     len;
    shape_e sh;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       set_dims(0);
        1:       set_dims($urandom_range(17, 40));
        default: set_dims($urandom_range(1, 8));
      endcase
      feed_gap_max = $urandom_range(1) ? 9 : 0;
      sink_gap_max = $urandom_range(1) ? 9 : 0;
      repeat ($urandom_range(10, 25)) begin
        action = $urandom_range(99);
        len    = vec_len();
        sh     = shape_e'($urandom_range(SHAPE_RANDOM));
        if (action < 15) begin
          repeat (len) send_elem(CMD_QUERY, pick_value());
        end else if (action < 70) begin
          repeat (len) send_cand_elem(sh);
        end else if (action < 80) begin
          repeat ($urandom_range(1, len)) send_cand_elem(sh);
        end else if (action < 85) begin
          repeat ($urandom_range(1, len)) send_elem(CMD_QUERY, pick_value());
        end else begin
          repeat ($urandom_range(1, len)) begin
            if ($urandom_range(1) && query_seen[cand_slot()])
              send_elem(CMD_CAND, pick_value());
            else
              send_elem(CMD_QUERY, pick_value());
          end
        end
      end
    end
    sink_gap_max = 9;
  endtask

  initial begin : main_seq
    qnorm_ref    = 0;
    cand_norm    = 0;
    dot_acc      = 0;
    query_at     = 0;
    cand_at      = 0;
    cand_idx     = '0;
    dims_reg     = DIMS_RESET;
    error_count  = 0;
    items_sent   = 0;
    feed_gap_max = 9;
    sink_gap_max = 9;
    sink_hold    = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_QUERY;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_value();
    test_degenerate();
    test_extremes();
    test_overshoot();
    test_query_restart();
    test_length_change();
    test_widest();
    test_backpressure();
    test_random();

    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
